### rtl/mfmtrk_pkg.sv
package mfmtrk_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_CYLINDER     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_HEAD_NUMBER  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SECTORS      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_SIZE_CODE    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TRACK_LENGTH = 3'd4;

	localparam logic [7:0]  RST_CYLINDER     = 8'd0;
	localparam logic [7:0]  RST_HEAD_NUMBER  = 8'd0;
	localparam logic [7:0]  RST_SECTORS      = 8'd9;
	localparam logic [3:0]  RST_SIZE_CODE    = 4'd2;
	localparam logic [15:0] RST_TRACK_LENGTH = 16'd12500;

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] SYNC_WORD  = 16'h4489;
	localparam logic [7:0]  GAP_BYTE   = 8'h4E;
	localparam logic [7:0]  ID_MARK    = 8'hFE;
	localparam logic [7:0]  DATA_MARK  = 8'hFB;
	localparam logic [7:0]  DEL_MARK   = 8'hF8;
	localparam logic [7:0]  SYNC_BYTE  = 8'hA1;

	localparam logic [16:0] GAP4A_LEN  = 17'd80;
	localparam logic [16:0] GAP2_LEN   = 17'd22;
	localparam logic [16:0] GAP3_LEN   = 17'd54;
	localparam logic [16:0] ZEROS_LEN  = 17'd12;
	localparam logic [16:0] SYNC_LEN   = 17'd3;
	localparam logic [16:0] ID_LEN     = 17'd7;
	localparam logic [16:0] MARK_LEN   = 17'd1;
	localparam logic [16:0] CRC_LEN    = 17'd2;
	localparam logic [16:0] SECTOR_MIN = 17'd128;
	localparam logic [3:0]  SIZE_MAX   = 4'd8;

	typedef enum logic [3:0] {
		PH_GAP4A      = 4'd0,
		PH_ID_ZEROS   = 4'd1,
		PH_ID_SYNC    = 4'd2,
		PH_ID_FIELD   = 4'd3,
		PH_GAP2       = 4'd4,
		PH_DATA_ZEROS = 4'd5,
		PH_DATA_SYNC  = 4'd6,
		PH_DATA_MARK  = 4'd7,
		PH_DATA       = 4'd8,
		PH_DATA_CRC   = 4'd9,
		PH_GAP3       = 4'd10,
		PH_PAD        = 4'd11
	} phase_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] data_byte;
		logic       sector_deleted;
	} cmd_t;

	typedef struct packed {
		logic        word_valid;
		logic [15:0] raw_word;
		logic        half_word;
		logic        byte_taken;
		logic        track_end;
	} res_t;

	typedef struct packed {
		logic [7:0]  cylinder;
		logic [7:0]  head_number;
		logic [7:0]  sectors_per_track;
		logic [3:0]  size_code;
		logic [15:0] track_length_bytes;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// clock cell set only between two zero data bits
	function automatic logic [15:0] mfm_byte(input logic prev, input logic [7:0] d);
		logic [15:0] raw;
		logic p;
		p = prev;
		raw = '0;
		for (int i = 7; i >= 0; i--) begin
			raw[2*i+1] = ~p & ~d[i];
			raw[2*i]   = d[i];
			p          = d[i];
		end
		return raw;
	endfunction

endpackage

### rtl/mfmtrk_layout.sv
module mfmtrk_layout (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mfmtrk_pkg::cmd_t   cmd,
	input  mfmtrk_pkg::cfg_t   cfg,
	output mfmtrk_pkg::res_t   res
);
	import mfmtrk_pkg::*;

	logic        running_q;
	phase_t      phase_q;
	logic [15:0] cnt_q;
	logic [7:0]  sector_q;
	logic [15:0] crc_q;
	logic        prev_q;
	logic [15:0] left_q;

	phase_t      phase_nxt;
	logic [15:0] cnt_nxt;
	logic [7:0]  sector_nxt;
	logic [15:0] crc_nxt;
	logic        prev_nxt;
	logic [15:0] left_nxt;

	logic [15:0] cur_left;
	logic        go;
	logic        half;
	logic        last;
	logic        sync;
	logic        taken;
	logic [7:0]  b;
	logic [15:0] w;
	logic [15:0] word;
	logic [16:0] cnt_inc;
	logic [16:0] adv_lim;
	phase_t      adv_next;
	logic        adv_en;
	logic [3:0]  eff_code;
	logic [16:0] data_lim;

	assign eff_code = (cfg.size_code > SIZE_MAX) ? SIZE_MAX : cfg.size_code;
	assign data_lim = SECTOR_MIN << eff_code;
	assign cnt_inc  = {1'b0, cnt_q} + 17'd1;
	assign cur_left = running_q ? left_q : cfg.track_length_bytes;
	assign go       = running_q || (cmd.start_req && (cfg.track_length_bytes != 16'd0));

	always_comb begin
		b          = GAP_BYTE;
		sync       = 1'b0;
		taken      = 1'b0;
		crc_nxt    = crc_q;
		sector_nxt = sector_q;
		adv_en     = 1'b1;
		adv_lim    = GAP4A_LEN;
		adv_next   = PH_PAD;
		unique case (phase_q)
			PH_GAP4A: begin
				adv_lim  = GAP4A_LEN;
				adv_next = (cfg.sectors_per_track == 8'd0) ? PH_PAD : PH_ID_ZEROS;
			end
			PH_ID_ZEROS, PH_DATA_ZEROS: begin
				b = 8'h00;
				if (cnt_q == 16'd0) begin
					crc_nxt = CRC_PRESET;
				end
				adv_lim  = ZEROS_LEN;
				adv_next = (phase_q == PH_ID_ZEROS) ? PH_ID_SYNC : PH_DATA_SYNC;
			end
			PH_ID_SYNC, PH_DATA_SYNC: begin
				sync     = 1'b1;
				crc_nxt  = crc_byte(crc_q, SYNC_BYTE);
				adv_lim  = SYNC_LEN;
				adv_next = (phase_q == PH_ID_SYNC) ? PH_ID_FIELD : PH_DATA_MARK;
			end
			PH_ID_FIELD: begin
				unique case (cnt_q[2:0])
					3'd0:    b = ID_MARK;
					3'd1:    b = cfg.cylinder;
					3'd2:    b = cfg.head_number;
					3'd3:    b = sector_q;
					3'd4:    b = {4'd0, eff_code};
					3'd5:    b = crc_q[15:8];
					default: b = crc_q[7:0];
				endcase
				if (cnt_q < 16'd5) begin
					crc_nxt = crc_byte(crc_q, b);
				end
				adv_lim  = ID_LEN;
				adv_next = PH_GAP2;
			end
			PH_GAP2: begin
				adv_lim  = GAP2_LEN;
				adv_next = PH_DATA_ZEROS;
			end
			PH_DATA_MARK: begin
				b        = cmd.sector_deleted ? DEL_MARK : DATA_MARK;
				crc_nxt  = crc_byte(crc_q, b);
				adv_lim  = MARK_LEN;
				adv_next = PH_DATA;
			end
			PH_DATA: begin
				b        = cmd.data_byte;
				taken    = 1'b1;
				crc_nxt  = crc_byte(crc_q, b);
				adv_lim  = data_lim;
				adv_next = PH_DATA_CRC;
			end
			PH_DATA_CRC: begin
				b        = (cnt_q == 16'd0) ? crc_q[15:8] : crc_q[7:0];
				adv_lim  = CRC_LEN;
				adv_next = PH_GAP3;
			end
			PH_GAP3: begin
				adv_lim = GAP3_LEN;
				if (sector_q >= cfg.sectors_per_track) begin
					adv_next = PH_PAD;
				end else begin
					adv_next = PH_ID_ZEROS;
					if (cnt_inc >= GAP3_LEN) begin
						sector_nxt = sector_q + 8'd1;
					end
				end
			end
			default: begin
				adv_en = 1'b0;
			end
		endcase

		phase_nxt = phase_q;
		cnt_nxt   = cnt_q;
		if (adv_en) begin
			if (cnt_inc >= adv_lim) begin
				cnt_nxt   = '0;
				phase_nxt = adv_next;
			end else begin
				cnt_nxt = cnt_inc[15:0];
			end
		end

		w        = sync ? SYNC_WORD : mfm_byte(prev_q, b);
		prev_nxt = sync ? 1'b1 : b[0];

		// odd length: last word carries only its upper cells
		half     = cur_left < 16'd2;
		word     = w;
		left_nxt = cur_left - 16'd2;
		if (half) begin
			word     = (phase_q == PH_PAD) ? 16'h0000 : {w[15:8], 8'h00};
			left_nxt = '0;
		end
		last = (left_nxt == 16'd0);

		res.word_valid = go;
		res.raw_word   = go ? word : 16'h0000;
		res.half_word  = go & half;
		res.byte_taken = go & taken;
		res.track_end  = go & last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= PH_GAP4A;
			cnt_q     <= '0;
			sector_q  <= 8'd1;
			crc_q     <= CRC_PRESET;
			prev_q    <= 1'b0;
			left_q    <= '0;
		end else if (accept && go) begin
			if (last) begin
				running_q <= 1'b0;
				phase_q   <= PH_GAP4A;
				cnt_q     <= '0;
				sector_q  <= 8'd1;
				crc_q     <= CRC_PRESET;
				prev_q    <= 1'b0;
				left_q    <= '0;
			end else begin
				running_q <= 1'b1;
				phase_q   <= phase_nxt;
				cnt_q     <= cnt_nxt;
				sector_q  <= sector_nxt;
				crc_q     <= crc_nxt;
				prev_q    <= prev_nxt;
				left_q    <= left_nxt;
			end
		end
	end

endmodule

### rtl/mfm_ibm_track_encoder_unit.sv
// MFM track encoder for the IBM System/34 double-density layout.
// Command channel (cmd_valid/cmd_ready/cmd): every accepted word is one tick.
//   A tick with start_req set starts a track when idle; while a track runs
//   each tick produces the next 16-bit raw word and may consume data_byte.
// Result channel (res_valid/res_ready/res): exactly one word per command
//   word, in order. Idle ticks return an all-zero word (word_valid low).
// The result is registered: res_valid rises in the cycle after command accept.
// Throughput: one word per cycle; the command is taken while the output
//   register holds a result as long as that result is taken in the same
//   cycle. The path is one CRC byte update and one MFM byte encode.
// Stall: when res_ready is low and the output register is full, cmd_ready
//   drops and the track state holds.
// Configuration (cfg_we/cfg_index/cfg_data) is for the user to write
//   between tracks, unenforced; track length latched at start, rest live.
// Reset: no track running, configuration at its defaults (9 sectors,
//   size code 2, 12500 bytes), output register empty.
module mfm_ibm_track_encoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  mfmtrk_pkg::cmd_t                     cmd,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output mfmtrk_pkg::res_t                     res,
	input  logic                                 cfg_we,
	input  logic [mfmtrk_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [mfmtrk_pkg::CfgDataW-1:0]      cfg_data
);
	import mfmtrk_pkg::*;

	cfg_t cfg_q;
	res_t res_s1;
	res_t res_nxt;
	logic res_valid_s1;
	logic accept;

	assign cmd_ready = !res_valid_s1 || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cylinder           <= RST_CYLINDER;
			cfg_q.head_number        <= RST_HEAD_NUMBER;
			cfg_q.sectors_per_track  <= RST_SECTORS;
			cfg_q.size_code          <= RST_SIZE_CODE;
			cfg_q.track_length_bytes <= RST_TRACK_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYLINDER:     cfg_q.cylinder           <= cfg_data[7:0];
				CFG_HEAD_NUMBER:  cfg_q.head_number        <= cfg_data[7:0];
				CFG_SECTORS:      cfg_q.sectors_per_track  <= cfg_data[7:0];
				CFG_SIZE_CODE:    cfg_q.size_code          <= cfg_data[3:0];
				CFG_TRACK_LENGTH: cfg_q.track_length_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	mfmtrk_layout u_layout (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (accept) begin
			res_valid_s1 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_nxt;
		end
	end

	assign res_valid = res_valid_s1;
	assign res       = res_s1;

endmodule
